/* hw/rtl/c_string_literal_unescaper_macros.svh */
// Assertion macros for the C string literal unescaper.
// Needs clk and rst in the scope of the including module.
`ifndef C_STRING_LITERAL_UNESCAPER_MACROS_SVH
`define C_STRING_LITERAL_UNESCAPER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSLU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CSLU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/csl_unesc_pkg.sv */
// Types, codes and character constants for the C string literal unescaper.
// No dependencies.
`default_nettype none

package csl_unesc_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] err_t;

  localparam kind_t K_DATA = 2'd0;
  localparam kind_t K_END  = 2'd1;
  localparam kind_t K_ERR  = 2'd2;

  localparam err_t E_CHAR = 3'd0;
  localparam err_t E_ESC  = 3'd1;
  localparam err_t E_HEX  = 3'd2;
  localparam err_t E_U4   = 3'd3;
  localparam err_t E_U8   = 3'd4;
  localparam err_t E_ENC  = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  localparam logic [3:0] NEED_HEX = 4'd2;
  localparam logic [3:0] NEED_U4  = 4'd4;
  localparam logic [3:0] NEED_U8  = 4'd8;

  localparam logic [31:0] MAX_CODE   = 32'h0010_FFFF;
  localparam logic [31:0] SURR_FIRST = 32'h0000_D800;
  localparam logic [31:0] SURR_LAST  = 32'h0000_DFFF;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.nib = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/c_string_literal_unescaper.sv */
// C string literal unescaper: raw source bytes in, decoded bytes, end marks
// and error codes out. Uses csl_unesc_pkg and c_string_literal_unescaper_macros.svh.
//
// One byte is taken per cycle while in_ready is high. Each byte is decoded in
// the cycle it is transferred and its results (none to four) are written into
// a result group register, which drains one result per cycle while out_ready
// is high; a byte that gives one result therefore flows at one byte per cycle.
// A new byte is taken while the group is empty or its last result leaves in the
// same cycle, so a byte whose code point encodes to several UTF-8 bytes holds
// the input until its last result leaves. Quote, idle and escape-prefix bytes
// that give no result fill no group and cause no stall. Results carry kind,
// out_byte, error_code and last, with last set on the final result of each input byte.
`default_nettype none

module c_string_literal_unescaper
  import csl_unesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [2:0]      error_code,
  output logic            last
);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX  = 3'd3,
    M_U4   = 3'd4,
    M_U8   = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [31:0] code_accum, code_accum_next;

  logic             grp_valid;
  logic [1:0]       grp_idx;
  logic [1:0]       grp_top;
  kind_t            grp_kind;
  err_t             grp_err;
  logic [3:0][7:0]  grp_byte;

  logic [2:0]       res_cnt;
  kind_t            res_kind;
  err_t             res_err;
  logic [3:0][7:0]  res_byte;

  hex_digit_t  hv;
  logic [3:0]  need;
  err_t        digit_err;
  logic [3:0]  dc_inc;
  logic [31:0] acc_new;
  logic        accept, drain;

  assign accept   = in_valid && in_ready;
  assign drain    = out_valid && out_ready;
  assign in_ready = !grp_valid || (out_ready && grp_idx == grp_top);

  assign out_valid  = grp_valid;
  assign kind       = grp_kind;
  assign out_byte   = (grp_kind == K_DATA) ? grp_byte[grp_idx] : 8'd0;
  assign error_code = (grp_kind == K_ERR) ? grp_err : E_CHAR;
  assign last       = grp_idx == grp_top;

  assign hv      = hex_value(in_byte);
  assign dc_inc  = digit_count + 4'd1;
  assign acc_new = {code_accum[27:0], hv.nib};

  always_comb begin
    case (mode)
      M_HEX: begin
        need      = NEED_HEX;
        digit_err = E_HEX;
      end
      M_U4: begin
        need      = NEED_U4;
        digit_err = E_U4;
      end
      default: begin
        need      = NEED_U8;
        digit_err = E_U8;
      end
    endcase
  end

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    code_accum_next  = code_accum;
    res_cnt          = 3'd0;
    res_kind         = K_DATA;
    res_err          = E_CHAR;
    res_byte         = '0;
    case (mode)
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          mode_next = M_IDLE;
          res_cnt   = 3'd1;
          res_kind  = K_END;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
          res_cnt     = 3'd1;
          res_byte[0] = in_byte;
        end else begin
          mode_next = M_IDLE;
          res_cnt   = 3'd1;
          res_kind  = K_ERR;
          res_err   = E_CHAR;
        end
      end
      M_ESC: begin
        digit_count_next = 4'd0;
        code_accum_next  = 32'd0;
        mode_next        = M_STR;
        res_cnt          = 3'd1;
        case (in_byte)
          CH_QUOTE, CH_APOS, CH_QMARK, CH_BSLASH: res_byte[0] = in_byte;
          CH_ZERO: res_byte[0] = 8'h00;
          CH_A:    res_byte[0] = 8'h07;
          CH_B:    res_byte[0] = 8'h08;
          CH_F:    res_byte[0] = 8'h0C;
          CH_N:    res_byte[0] = 8'h0A;
          CH_R:    res_byte[0] = 8'h0D;
          CH_T:    res_byte[0] = 8'h09;
          CH_V:    res_byte[0] = 8'h0B;
          CH_X: begin
            mode_next = M_HEX;
            res_cnt   = 3'd0;
          end
          CH_LU: begin
            mode_next = M_U4;
            res_cnt   = 3'd0;
          end
          CH_UU: begin
            mode_next = M_U8;
            res_cnt   = 3'd0;
          end
          default: begin
            mode_next = M_IDLE;
            res_kind  = K_ERR;
            res_err   = E_ESC;
          end
        endcase
      end
      M_HEX, M_U4, M_U8: begin
        if (!hv.ok) begin
          mode_next        = M_IDLE;
          digit_count_next = 4'd0;
          code_accum_next  = 32'd0;
          res_cnt          = 3'd1;
          res_kind         = K_ERR;
          res_err          = digit_err;
        end else if (dc_inc < need) begin
          digit_count_next = dc_inc;
          code_accum_next  = acc_new;
        end else begin
          digit_count_next = 4'd0;
          code_accum_next  = 32'd0;
          mode_next        = M_STR;
          if (mode == M_HEX) begin
            res_cnt     = 3'd1;
            res_byte[0] = acc_new[7:0];
          end else if (acc_new > MAX_CODE ||
                       (acc_new >= SURR_FIRST && acc_new <= SURR_LAST)) begin
            mode_next = M_IDLE;
            res_cnt   = 3'd1;
            res_kind  = K_ERR;
            res_err   = E_ENC;
          end else if (acc_new < 32'h80) begin
            res_cnt     = 3'd1;
            res_byte[0] = acc_new[7:0];
          end else if (acc_new < 32'h800) begin
            res_cnt     = 3'd2;
            res_byte[0] = {3'b110, acc_new[10:6]};
            res_byte[1] = {2'b10, acc_new[5:0]};
          end else if (acc_new < 32'h1_0000) begin
            res_cnt     = 3'd3;
            res_byte[0] = {4'b1110, acc_new[15:12]};
            res_byte[1] = {2'b10, acc_new[11:6]};
            res_byte[2] = {2'b10, acc_new[5:0]};
          end else begin
            res_cnt     = 3'd4;
            res_byte[0] = {5'b11110, acc_new[20:18]};
            res_byte[1] = {2'b10, acc_new[17:12]};
            res_byte[2] = {2'b10, acc_new[11:6]};
            res_byte[3] = {2'b10, acc_new[5:0]};
          end
        end
      end
      default: begin
        mode_next = (in_byte == CH_QUOTE) ? M_STR : M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      digit_count <= 4'd0;
      code_accum  <= 32'd0;
      grp_valid   <= 1'b0;
      grp_idx     <= 2'd0;
      grp_top     <= 2'd0;
    end else begin
      if (accept) begin
        mode        <= mode_next;
        digit_count <= digit_count_next;
        code_accum  <= code_accum_next;
      end
      if (accept && res_cnt != 3'd0) begin
        grp_valid <= 1'b1;
        grp_idx   <= 2'd0;
        grp_top   <= 2'(res_cnt - 3'd1);
      end else if (drain) begin
        if (last) begin
          grp_valid <= 1'b0;
        end else begin
          grp_idx <= grp_idx + 2'd1;
        end
      end
    end
  end

  // Hold payload of the result group
  always_ff @(posedge clk) begin
    if (accept && res_cnt != 3'd0) begin
      grp_kind <= res_kind;
      grp_err  <= res_err;
      grp_byte <= res_byte;
    end
  end

`include "c_string_literal_unescaper_macros.svh"

  `CSLU_ASSERT_IMP(a_single_non_data, out_valid && grp_kind != K_DATA,
    grp_top == 2'd0, "non-data result in a multi-result group")
  `CSLU_ASSERT_IMP(a_utf8_lead, out_valid && grp_top != 2'd0 && grp_idx == 2'd0,
    out_byte[7:6] == 2'b11, "multi-byte group does not start with a UTF-8 lead byte")
  `CSLU_ASSERT_NXT(a_error_to_idle, accept && res_cnt != 3'd0 && res_kind == K_ERR,
    mode == M_IDLE && digit_count == 4'd0 && code_accum == 32'd0,
    "error did not return to idle")
  `CSLU_ASSERT_IMP(a_count_scope, mode == M_IDLE || mode == M_STR || mode == M_ESC,
    digit_count == 4'd0, "digit count left outside hex escape")
  `CSLU_ASSERT_IMP(a_count_bound, 1'b1, digit_count < NEED_U8, "digit count out of range")

endmodule

`default_nettype wire

/* sim/c_string_literal_unescaper_tb.sv */
`timescale 1ns / 100ps
// Testbench for c_string_literal_unescaper: directed table plus random string streams,
// checked against a local unescape predictor. Depends on csl_unesc_pkg and the RTL.

module c_string_literal_unescaper_tb;
  import csl_unesc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 16;
  localparam int LONG_HOLD   = 120;

  typedef enum logic [2:0] {ST_IDLE, ST_STR, ST_ESC, ST_HEX, ST_U4, ST_U8} scan_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
    logic       last;
  } result_t;

  typedef struct {
    logic [7:0] b;
    int         n;
    result_t    r;
  } row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  scan_mode_e scan_mode = ST_IDLE;
  logic [3:0] digits = 4'd0;
  logic [31:0] code_val = 32'd0;

  result_t    decoded_q[$];
  logic [7:0] src_bytes[$];
  row_t       directed_rows[$];

  int src_pct = 0;
  int sink_pct = 0;
  int hold_req = 0;
  int n_fail = 0;
  int n_sent = 0;
  int n_data = 0;
  int n_end = 0;
  int n_err = 0;
  int cycles = 0;

  c_string_literal_unescaper u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .error_code (error_code),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t mk(kind_t k, logic [7:0] b, err_t e, logic l);
    result_t r;
    r.kind = k;
    r.data = (k == K_DATA) ? b : 8'h00;
    r.code = (k == K_ERR) ? e : 3'd0;
    r.last = l;
    return r;
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic unescape_byte(input logic [7:0] c);
    result_t    res[$];
    logic [4:0] nib;
    logic [3:0] need;
    logic [31:0] w;
    logic       bad;
    err_t       why;
    int         i;
    bad = 1'b0;
    why = E_CHAR;
    case (scan_mode)
      ST_STR: begin
        if (c == CH_QUOTE) begin
          scan_mode = ST_IDLE;
          res.push_back(mk(K_END, 8'h00, E_CHAR, 1'b0));
        end else if (c == CH_BSLASH) begin
          scan_mode = ST_ESC;
        end else if (c >= CH_SPACE && c <= CH_TILDE) begin
          res.push_back(mk(K_DATA, c, E_CHAR, 1'b0));
        end else begin
          bad = 1'b1;
          why = E_CHAR;
        end
      end
      ST_ESC: begin
        digits = 4'd0;
        code_val = 32'd0;
        scan_mode = ST_STR;
        case (c)
          CH_QUOTE, CH_APOS, CH_QMARK, CH_BSLASH: res.push_back(mk(K_DATA, c, E_CHAR, 1'b0));
          CH_ZERO: res.push_back(mk(K_DATA, 8'h00, E_CHAR, 1'b0));
          CH_A:    res.push_back(mk(K_DATA, 8'h07, E_CHAR, 1'b0));
          CH_B:    res.push_back(mk(K_DATA, 8'h08, E_CHAR, 1'b0));
          CH_F:    res.push_back(mk(K_DATA, 8'h0C, E_CHAR, 1'b0));
          CH_N:    res.push_back(mk(K_DATA, 8'h0A, E_CHAR, 1'b0));
          CH_R:    res.push_back(mk(K_DATA, 8'h0D, E_CHAR, 1'b0));
          CH_T:    res.push_back(mk(K_DATA, 8'h09, E_CHAR, 1'b0));
          CH_V:    res.push_back(mk(K_DATA, 8'h0B, E_CHAR, 1'b0));
          CH_X:    scan_mode = ST_HEX;
          CH_LU:   scan_mode = ST_U4;
          CH_UU:   scan_mode = ST_U8;
          default: begin
            bad = 1'b1;
            why = E_ESC;
          end
        endcase
      end
      ST_HEX, ST_U4, ST_U8: begin
        need = (scan_mode == ST_HEX) ? NEED_HEX : (scan_mode == ST_U4) ? NEED_U4 : NEED_U8;
        why = (scan_mode == ST_HEX) ? E_HEX : (scan_mode == ST_U4) ? E_U4 : E_U8;
        nib = hex_nibble(c);
        if (!nib[4]) begin
          bad = 1'b1;
        end else begin
          code_val = {code_val[27:0], nib[3:0]};
          digits = digits + 4'd1;
          if (digits == need) begin
            w = code_val;
            digits = 4'd0;
            code_val = 32'd0;
            if (scan_mode == ST_HEX) begin
              res.push_back(mk(K_DATA, w[7:0], E_CHAR, 1'b0));
            end else if (w > MAX_CODE || (w >= SURR_FIRST && w <= SURR_LAST)) begin
              bad = 1'b1;
              why = E_ENC;
            end else if (w < 32'h80) begin
              res.push_back(mk(K_DATA, w[7:0], E_CHAR, 1'b0));
            end else if (w < 32'h800) begin
              res.push_back(mk(K_DATA, {3'b110, w[10:6]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[5:0]}, E_CHAR, 1'b0));
            end else if (w < 32'h10000) begin
              res.push_back(mk(K_DATA, {4'b1110, w[15:12]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[11:6]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[5:0]}, E_CHAR, 1'b0));
            end else begin
              res.push_back(mk(K_DATA, {5'b11110, w[20:18]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[17:12]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[11:6]}, E_CHAR, 1'b0));
              res.push_back(mk(K_DATA, {2'b10, w[5:0]}, E_CHAR, 1'b0));
            end
            scan_mode = ST_STR;
          end
        end
      end
      default: scan_mode = (c == CH_QUOTE) ? ST_STR : ST_IDLE;
    endcase
    if (bad) begin
      res.delete();
      res.push_back(mk(K_ERR, 8'h00, why, 1'b0));
      scan_mode = ST_IDLE;
      digits = 4'd0;
      code_val = 32'd0;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    for (i = 0; i < res.size(); i++) decoded_q.push_back(res[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input int n_typed, input result_t typed);
    int base;
    while ($urandom_range(99) < src_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    base = decoded_q.size();
    unescape_byte(b);
    if (n_typed >= 0) begin
      while (decoded_q.size() > base) void'(decoded_q.pop_back());
      if (n_typed == 1) decoded_q.push_back(typed);
    end
    n_sent++;
  endtask

  task automatic drain_results;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic tab(input logic [7:0] b, input int n, input kind_t k, input logic [7:0] d,
                     input err_t e);
    row_t r;
    r.b = b;
    r.n = n;
    r.r = mk(k, d, e, 1'b1);
    directed_rows.push_back(r);
  endtask

  task automatic add_hex(input logic [31:0] v, input int nd);
    logic [3:0] nib;
    int i;
    for (i = nd - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) src_bytes.push_back(8'h30 + nib);
      else src_bytes.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
    end
  endtask

  function automatic logic [7:0] simple_escape;
    case ($urandom_range(11))
      0: return CH_QUOTE;
      1: return CH_APOS;
      2: return CH_QMARK;
      3: return CH_BSLASH;
      4: return CH_ZERO;
      5: return CH_A;
      6: return CH_B;
      7: return CH_F;
      8: return CH_N;
      9: return CH_R;
      10: return CH_T;
      default: return CH_V;
    endcase
  endfunction

  function automatic logic [31:0] pick_code(input bit wide);
    logic [31:0] w;
    case ($urandom_range(3))
      0: w = $urandom_range(32'h7F);
      1: w = $urandom_range(32'h7FF, 32'h80);
      2: begin
        do w = $urandom_range(32'hFFFF, 32'h800);
        while (w >= SURR_FIRST && w <= SURR_LAST);
      end
      default: begin
        if (wide) begin
          w = $urandom_range(MAX_CODE, 32'h10000);
        end else begin
          do w = $urandom_range(32'hFFFF, 32'h800);
          while (w >= SURR_FIRST && w <= SURR_LAST);
        end
      end
    endcase
    return w;
  endfunction

  task automatic add_string;
    logic [7:0] c;
    int n_tok;
    int t;
    int cls;
    int sel;
    src_bytes.push_back(CH_QUOTE);
    n_tok = $urandom_range(8, 1);
    for (t = 0; t < n_tok; t++) begin
      cls = $urandom_range(99);
      if (cls < 40) begin
        do c = 8'($urandom_range(CH_TILDE, CH_SPACE));
        while (c == CH_QUOTE || c == CH_BSLASH);
        src_bytes.push_back(c);
      end else if (cls < 55) begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(simple_escape());
      end else if (cls < 65) begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(CH_X);
        add_hex($urandom_range(255), 2);
      end else if (cls < 77) begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(CH_LU);
        add_hex(pick_code(1'b0), 4);
      end else if (cls < 90) begin
        src_bytes.push_back(CH_BSLASH);
        src_bytes.push_back(CH_UU);
        add_hex(pick_code(1'b1), 8);
      end else begin
        sel = $urandom_range(3);
        case (sel)
          0: src_bytes.push_back(8'($urandom_range(255)));
          1: begin
            src_bytes.push_back(CH_BSLASH);
            src_bytes.push_back(8'($urandom_range(255)));
          end
          2: begin
            src_bytes.push_back(CH_BSLASH);
            case ($urandom_range(2))
              0: begin
                src_bytes.push_back(CH_X);
                add_hex($urandom_range(255), $urandom_range(1));
              end
              1: begin
                src_bytes.push_back(CH_LU);
                add_hex($urandom, $urandom_range(3));
              end
              default: begin
                src_bytes.push_back(CH_UU);
                add_hex($urandom, $urandom_range(7));
              end
            endcase
            src_bytes.push_back(8'($urandom_range(255)));
          end
          default: begin
            src_bytes.push_back(CH_BSLASH);
            if ($urandom_range(1)) begin
              src_bytes.push_back(CH_LU);
              add_hex($urandom_range(SURR_LAST, SURR_FIRST), 4);
            end else begin
              src_bytes.push_back(CH_UU);
              add_hex($urandom_range(32'hFFFF_FFFF, MAX_CODE + 1), 8);
            end
          end
        endcase
      end
    end
    if ($urandom_range(19) != 0) src_bytes.push_back(CH_QUOTE);
  endtask

  task automatic run_phase(input int sp, input int kp, input int n_items, input int hold);
    int counted;
    int mark;
    int nz;
    src_bytes.delete();
    counted = 0;
    while (counted < n_items) begin
      mark = src_bytes.size();
      nz = $urandom_range(2);
      repeat (nz) src_bytes.push_back(8'($urandom_range(255)));
      add_string();
      counted += src_bytes.size() - mark;
    end
    src_pct = sp;
    sink_pct = kp;
    if (hold > 0) hold_req = hold;
    foreach (src_bytes[k]) send_byte(src_bytes[k], -1, '0);
    in_valid <= 1'b0;
    drain_results();
  endtask

  // result checker and receiver stall control
  initial begin
    result_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (kind == K_DATA) n_data++;
        else if (kind == K_END) n_end++;
        else n_err++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %02h, error_code %0d, last %0b",
                 kind, out_byte, error_code, last);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            n_fail++;
          end
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            n_fail++;
          end
          if (error_code !== want.code) begin
            $error("error_code: expected %0d, got %0d", want.code, error_code);
            n_fail++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            n_fail++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $error("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n_directed;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tab(8'hFF, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_SPACE, 1, K_DATA, CH_SPACE, E_CHAR);
    tab(CH_TILDE, 1, K_DATA, CH_TILDE, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_X, 0, K_DATA, 8'h00, E_CHAR);
    tab("F", 0, K_DATA, 8'h00, E_CHAR);
    tab("f", 1, K_DATA, 8'hFF, E_CHAR);
    tab(8'h00, 1, K_ERR, 8'h00, E_CHAR);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab("q", 1, K_ERR, 8'h00, E_ESC);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_X, 0, K_DATA, 8'h00, E_CHAR);
    tab("g", 1, K_ERR, 8'h00, E_HEX);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_LU, 0, K_DATA, 8'h00, E_CHAR);
    tab("G", 1, K_ERR, 8'h00, E_U4);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_UU, 0, K_DATA, 8'h00, E_CHAR);
    tab("@", 1, K_ERR, 8'h00, E_U8);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_BSLASH, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_LU, 0, K_DATA, 8'h00, E_CHAR);
    tab("D", 0, K_DATA, 8'h00, E_CHAR);
    tab("F", 0, K_DATA, 8'h00, E_CHAR);
    tab("F", 0, K_DATA, 8'h00, E_CHAR);
    tab("F", 1, K_ERR, 8'h00, E_ENC);
    tab(CH_QUOTE, 0, K_DATA, 8'h00, E_CHAR);
    tab(CH_QUOTE, 1, K_END, 8'h00, E_CHAR);

    foreach (directed_rows[i]) send_byte(directed_rows[i].b, directed_rows[i].n,
                                         directed_rows[i].r);
    in_valid <= 1'b0;
    drain_results();
    n_directed = n_sent;

    run_phase(0, 0, 20, 0);
    run_phase(46, 0, 20, 0);
    run_phase(0, 46, 20, LONG_HOLD);
    run_phase(37, 37, 20, 0);

    $display("Sent %0d bytes (%0d directed); checked %0d data, %0d end, %0d error results",
             n_sent, n_directed, n_data, n_end, n_err);
    $display("Covered plain text, all escapes, 1-4 byte UTF-8, every error code, stalls");
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
